FILE: design/assert_macros.svh
// Assertion macros for the RTL file that checks its own behavior (sha256_stream_hasher).
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/sha256_pkg.sv
// Shared types and constants for the SHA-256 stream hasher.
// Depends on nothing; used by sha256_core and sha256_stream_hasher.
package sha256_pkg;

    localparam int WORD_W  = 32;
    localparam int ROUNDS  = 64;
    localparam int TOTAL_W = 61;

    localparam logic [7:0] PAD_MARKER = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        final_word;
    } out_item_t;

    typedef logic [7:0][WORD_W-1:0] hash_t;

    // Commands from the control sequencer to the compression core.
    typedef struct packed {
        logic       shift_en;
        logic [7:0] shift_byte;
        logic       start;
        logic       init;
    } core_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    localparam hash_t INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [WORD_W-1:0] ROUND_K [0:ROUNDS-1] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

FILE: design/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: byte intake, padding and digest output.
// Depends on sha256_pkg, sha256_core and assert_macros.svh.
//
//  Channel   Ports                       Item
//  input     s_valid, s_ready, s_item    one message byte with present/end flags
//  output    m_valid, m_ready, m_item    one digest word with index and last flag
//
// A byte item is taken whenever the input is ready; the 64th byte of a block also
// starts the 64 rounds of the compression core, the chaining add and its handoff.
// A closing item pads one byte per cycle up to the block end and compresses
// once or twice, then offers eight digest words, one per accepted handshake.
// The input is not ready while a block compresses, padding runs or words wait.
// Reset loads the initial hash values and clears the byte count.
module sha256_stream_hasher (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sha256_pkg::in_item_t  s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sha256_pkg::out_item_t m_item
);
    import sha256_pkg::*;

    `include "assert_macros.svh"

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_DATA_WAIT = 3'd1;
    localparam logic [2:0] ST_PAD       = 3'd2;
    localparam logic [2:0] ST_PAD_WAIT  = 3'd3;
    localparam logic [2:0] ST_EMIT      = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [5:0]         pos_reg, pos_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               closing_reg, closing_next;
    logic               pad_first_reg, pad_first_next;
    logic               spill_reg, spill_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_item_reg, m_item_next;

    core_ctrl_t ctrl;
    core_stat_t stat;
    hash_t      chain_hash;

    logic [63:0] len_bits;
    logic [5:0]  len_shift;
    logic [7:0]  len_byte;
    logic [2:0]  next_word;

    sha256_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .stat       (stat),
        .chain_hash (chain_hash)
    );

    // Length bytes go out most significant first; position 56 + j carries byte j.
    assign len_bits  = {total_reg, 3'b000};
    assign len_shift = {~pos_reg[2:0], 3'b000};
    assign len_byte  = len_bits[len_shift +: 8];
    assign next_word = m_item_reg.word_number + 3'd1;

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        total_next     = total_reg;
        closing_next   = closing_reg;
        pad_first_next = pad_first_reg;
        spill_next     = spill_reg;
        m_valid_next   = m_valid_reg;
        m_item_next    = m_item_reg;
        ctrl           = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    closing_next = s_item.end_of_message;
                    if (s_item.byte_present) begin
                        ctrl.shift_en   = 1'b1;
                        ctrl.shift_byte = s_item.data_byte;
                        pos_next        = pos_reg + 6'd1;
                        total_next      = total_reg + TOTAL_W'(1);
                    end
                    if (s_item.byte_present && pos_reg == 6'd63) begin
                        ctrl.start = 1'b1;
                        state_next = ST_DATA_WAIT;
                    end else if (s_item.end_of_message) begin
                        pad_first_next = 1'b1;
                        state_next     = ST_PAD;
                    end
                end
            end
            ST_DATA_WAIT: begin
                if (stat.done) begin
                    if (closing_reg) begin
                        pad_first_next = 1'b1;
                        state_next     = ST_PAD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PAD: begin
                ctrl.shift_en  = 1'b1;
                pad_first_next = 1'b0;
                pos_next       = pos_reg + 6'd1;
                if (pad_first_reg) begin
                    // A marker in the last eight positions leaves no room for the length.
                    ctrl.shift_byte = PAD_MARKER;
                    spill_next      = (pos_reg[5:3] == 3'b111);
                end else if (pos_reg[5:3] == 3'b111 && !spill_reg) begin
                    ctrl.shift_byte = len_byte;
                end else begin
                    ctrl.shift_byte = 8'h00;
                end
                if (pos_reg == 6'd63) begin
                    ctrl.start = 1'b1;
                    state_next = ST_PAD_WAIT;
                end
            end
            ST_PAD_WAIT: begin
                if (stat.done) begin
                    if (spill_reg) begin
                        spill_next = 1'b0;
                        state_next = ST_PAD;
                    end else begin
                        m_valid_next            = 1'b1;
                        m_item_next.digest_word = chain_hash[0];
                        m_item_next.word_number = 3'd0;
                        m_item_next.final_word  = 1'b0;
                        total_next              = '0;
                        state_next              = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (m_ready) begin
                    if (m_item_reg.final_word) begin
                        m_valid_next = 1'b0;
                        ctrl.init    = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        m_item_next.digest_word = chain_hash[next_word];
                        m_item_next.word_number = next_word;
                        m_item_next.final_word  = (next_word == 3'd7);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            total_reg     <= '0;
            closing_reg   <= 1'b0;
            pad_first_reg <= 1'b0;
            spill_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            total_reg     <= total_next;
            closing_reg   <= closing_next;
            pad_first_reg <= pad_first_next;
            spill_reg     <= spill_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `ASSERT_SAME(a_no_intake_during_output, aclk, aresetn, s_ready, !m_valid, "input ready while digest words wait")
    `ASSERT_SAME(a_start_only_when_idle, aclk, aresetn, ctrl.start, !stat.busy, "core started while busy")
    `ASSERT_NEXT(a_words_continue, aclk, aresetn, m_valid && m_ready && !m_item.final_word, m_valid, "digest stopped before the last word")
    `ASSERT_NEXT(a_ready_after_digest, aclk, aresetn, m_valid && m_ready && m_item.final_word, s_ready && chain_hash == INIT_HASH, "no return to initial state after digest")

endmodule

FILE: design/sha256_core.sv
// SHA-256 compression core: 512-bit block window, one round per cycle.
// Depends on sha256_pkg for the command types and constants.
module sha256_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sha256_pkg::core_ctrl_t ctrl,
    output sha256_pkg::core_stat_t stat,
    output sha256_pkg::hash_t      chain_hash
);
    import sha256_pkg::*;

    localparam logic [1:0] C_IDLE  = 2'd0;
    localparam logic [1:0] C_ROUND = 2'd1;
    localparam logic [1:0] C_ADD   = 2'd2;

    logic [1:0]   state_reg, state_next;
    logic [5:0]   round_reg, round_next;
    logic         done_reg, done_next;
    logic [511:0] window_reg, window_next;
    hash_t        chain_reg, chain_next;
    hash_t        work_reg, work_next;

    logic [WORD_W-1:0] w0, w1, w9, w14, w_new;
    logic [WORD_W-1:0] ep0, ep1, choose, major, sum1, sum2;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                               input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    // The window holds the next sixteen schedule words, oldest at the top.
    assign w0  = window_reg[511:480];
    assign w1  = window_reg[479:448];
    assign w9  = window_reg[223:192];
    assign w14 = window_reg[63:32];

    assign w_new = (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10)) + w9
                 + (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w0;

    assign ep1    = rotr(work_reg[4], 6) ^ rotr(work_reg[4], 11) ^ rotr(work_reg[4], 25);
    assign choose = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign ep0    = rotr(work_reg[0], 2) ^ rotr(work_reg[0], 13) ^ rotr(work_reg[0], 22);
    assign major  = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                  ^ (work_reg[1] & work_reg[2]);
    assign sum1   = work_reg[7] + ep1 + choose + ROUND_K[round_reg] + w0;
    assign sum2   = ep0 + major;

    always_comb begin
        state_next  = state_reg;
        round_next  = round_reg;
        done_next   = 1'b0;
        window_next = window_reg;
        chain_next  = chain_reg;
        work_next   = work_reg;

        if (ctrl.shift_en) begin
            window_next = {window_reg[503:0], ctrl.shift_byte};
        end
        if (ctrl.init) begin
            chain_next = INIT_HASH;
        end

        unique case (state_reg)
            C_IDLE: begin
                if (ctrl.start) begin
                    work_next  = chain_reg;
                    round_next = '0;
                    state_next = C_ROUND;
                end
            end
            C_ROUND: begin
                window_next  = {window_reg[479:0], w_new};
                work_next[7] = work_reg[6];
                work_next[6] = work_reg[5];
                work_next[5] = work_reg[4];
                work_next[4] = work_reg[3] + sum1;
                work_next[3] = work_reg[2];
                work_next[2] = work_reg[1];
                work_next[1] = work_reg[0];
                work_next[0] = sum1 + sum2;
                round_next   = round_reg + 6'd1;
                if (round_reg == 6'(ROUNDS - 1)) begin
                    state_next = C_ADD;
                end
            end
            C_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            round_reg <= '0;
            done_reg  <= 1'b0;
            chain_reg <= INIT_HASH;
        end else begin
            state_reg <= state_next;
            round_reg <= round_next;
            done_reg  <= done_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge aclk) begin
        window_reg <= window_next;
        work_reg   <= work_next;
    end

    assign stat.busy  = (state_reg != C_IDLE);
    assign stat.done  = done_reg;
    assign chain_hash = chain_reg;

endmodule
